@@ src/sensor_heartbeat_safety_interlock_unit_defines.svh @@
// Assertion helpers for the sensor heartbeat safety interlock.
// Each one checks on the rising edge of i_clk and stays quiet while i_rst_n is low.
`ifndef SENSOR_HEARTBEAT_SAFETY_INTERLOCK_UNIT_DEFINES_SVH
`define SENSOR_HEARTBEAT_SAFETY_INTERLOCK_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SHSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SHSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/shsi_pkg.sv @@
`timescale 1ns / 1ps
package shsi_pkg;

    localparam int MASK_W     = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SLOT_IN_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_BYPASS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60000;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_REPORT  = 4'b0010,
        S_TICK    = 4'b0100,
        S_VERDICT = 4'b1000
    } t_state;

endpackage

@@ src/sensor_heartbeat_safety_interlock_unit.sv @@
// Report transaction: the slot is updated in S_REPORT, then S_VERDICT registers the result and strobe.
// Tick transaction: S_TICK walks every slot, then S_VERDICT; one shared saturating incrementer and
// timeout comparator walks the slots, one slot per cycle.
// busy drops with the strobe.
// Synchronous active-low reset: all ages zero, all slots offline and unsafe,
// registers back to their defaults (timeout 60000).
`timescale 1ns / 1ps
`include "sensor_heartbeat_safety_interlock_unit_defines.svh"
module sensor_heartbeat_safety_interlock_unit #(
    parameter int SLOT_COUNT = 8,
    parameter int AGE_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [shsi_pkg::SLOT_IN_W-1:0]  i_sensor_slot,
    input  logic                            i_report_safe,
    input  logic                            i_cfg_we,
    input  logic [shsi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [shsi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_strobe,
    output logic                            o_weather_safe,
    output logic [shsi_pkg::MASK_W-1:0]     o_online_mask,
    output logic [shsi_pkg::MASK_W-1:0]     o_safe_mask
);
    import shsi_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = (AGE_BITS > TIMEOUT_W) ? AGE_BITS : TIMEOUT_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    t_state r_state, n_state;

    logic [MASK_W-1:0]    r_enable;
    logic [MASK_W-1:0]    r_bypass;
    logic                 r_gbypass;
    logic [TIMEOUT_W-1:0] r_timeout;

    logic [AGE_BITS-1:0]   r_age [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_online;
    logic [SLOT_COUNT-1:0] r_safe;

    logic [IDX_W-1:0]     r_idx;
    logic [SLOT_IN_W-1:0] r_slot;
    logic                 r_rsafe;

    logic              r_strobe;
    logic              r_out_safe;
    logic [MASK_W-1:0] r_out_online;
    logic [MASK_W-1:0] r_out_safe_mask;

    logic                accept;
    logic                slot_ok;
    logic [IDX_W-1:0]    slot_idx;
    logic [AGE_BITS-1:0] age_rd;
    logic [AGE_BITS-1:0] age_inc;
    logic                age_live;
    logic [MASK_W-1:0]   online8;
    logic [MASK_W-1:0]   safe8;
    logic [MASK_W-1:0]   active;
    logic                verdict;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign slot_ok  = (6'(r_slot) < 6'(SLOT_COUNT));
    assign slot_idx = IDX_W'(r_slot);

    // shared unit: saturating age increment and timeout compare
    assign age_rd   = r_age[r_idx];
    assign age_inc  = (age_rd == AGE_MAX) ? age_rd : age_rd + AGE_BITS'(1);
    assign age_live = (CMP_W'(age_inc) < CMP_W'(r_timeout));

    // slots from eight up never show in the masks
    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < SLOT_COUNT) begin : g_live
            assign online8[g] = r_online[g];
            assign safe8[g]   = r_safe[g];
        end else begin : g_none
            assign online8[g] = 1'b0;
            assign safe8[g]   = 1'b0;
        end
    end

    assign active  = r_enable & ~r_bypass;
    assign verdict = r_gbypass || ((active & ~(online8 & safe8)) == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_func == FUNC_TICK) ? S_TICK : S_REPORT;
                end
            end
            S_REPORT: n_state = S_VERDICT;
            S_TICK: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_VERDICT;
                end
            end
            S_VERDICT: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_strobe  <= 1'b0;
            r_enable  <= '0;
            r_bypass  <= '0;
            r_gbypass <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_VERDICT);
            if (r_state == S_TICK) begin
                r_idx <= r_idx + IDX_W'(1);
            end else begin
                r_idx <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE_MASK:   r_enable  <= i_cfg_data[MASK_W-1:0];
                    CFG_BYPASS_MASK:   r_bypass  <= i_cfg_data[MASK_W-1:0];
                    CFG_GLOBAL_BYPASS: r_gbypass <= i_cfg_data[0];
                    CFG_TIMEOUT_TICKS: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // hold the report fields for the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot  <= i_sensor_slot;
            r_rsafe <= i_report_safe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_age[s] <= '0;
            end
            r_online <= '0;
            r_safe   <= '0;
        end else if (r_state == S_TICK) begin
            r_age[r_idx]    <= age_inc;
            r_online[r_idx] <= age_live;
        end else if (r_state == S_REPORT && slot_ok) begin
            r_age[slot_idx]    <= '0;
            r_online[slot_idx] <= 1'b1;
            r_safe[slot_idx]   <= r_rsafe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_VERDICT) begin
            r_out_safe      <= verdict;
            r_out_online    <= online8;
            r_out_safe_mask <= safe8;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_weather_safe = r_out_safe;
    assign o_online_mask  = r_out_online;
    assign o_safe_mask    = r_out_safe_mask;

    `SHSI_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `SHSI_ASSERT_NEXT(a_verdict_strobe, r_state == S_VERDICT, o_strobe && !busy, "no strobe after verdict")
    `SHSI_ASSERT_NOW(a_tick_index, r_state == S_TICK, r_idx <= IDX_LAST, "slot walk ran past last slot")
    `SHSI_ASSERT_NEXT(a_bypass_safe, r_state == S_VERDICT && r_gbypass, o_weather_safe, "global bypass not safe")

endmodule

@@ bench/tb_sensor_heartbeat_safety_interlock_unit.sv @@
`timescale 1ns / 1ps
module tb_sensor_heartbeat_safety_interlock_unit;
    import shsi_pkg::*;

    localparam int SLOTS           = 8;
    localparam logic [15:0] AGE_SAT = 16'hFFFF;
    localparam int RUN_LIMIT       = 400000;
    localparam int RANDOM_PHASES   = 17;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 2 * SLOTS + 4;

    typedef struct packed {
        logic                 func;
        logic [SLOT_IN_W-1:0] slot;
        logic                 report_safe;
    } t_interlock_cmd;

    typedef struct packed {
        logic              weather_safe;
        logic [MASK_W-1:0] online_mask;
        logic [MASK_W-1:0] safe_mask;
    } t_interlock_status;

    typedef struct {
        bit                    is_reg_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_interlock_cmd        cmd;
        bit                    typed;
        t_interlock_status     status;
    } t_directed_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  i_func        = FUNC_REPORT;
    logic [SLOT_IN_W-1:0]  i_sensor_slot = '0;
    logic                  i_report_safe = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_ENABLE_MASK;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  busy;
    logic                  o_strobe;
    logic                  o_weather_safe;
    logic [MASK_W-1:0]     o_online_mask;
    logic [MASK_W-1:0]     o_safe_mask;

    // Interlock shadow state and registers
    logic [MASK_W-1:0]    enable_bits;
    logic [MASK_W-1:0]    bypass_bits;
    logic                 force_safe;
    logic [TIMEOUT_W-1:0] timeout_limit;
    logic [15:0]          slot_age_q [SLOTS];
    logic [MASK_W-1:0]    online_bits;
    logic [MASK_W-1:0]    safe_bits;

    t_interlock_status verdict_q [$];
    t_directed_row     directed_rows [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;

    sensor_heartbeat_safety_interlock_unit i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_interlock_status advance_interlock(t_interlock_cmd cmd);
        t_interlock_status status;
        logic [MASK_W-1:0] active;
        if (cmd.func == FUNC_REPORT) begin
            slot_age_q[cmd.slot]  = '0;
            online_bits[cmd.slot] = 1'b1;
            safe_bits[cmd.slot]   = cmd.report_safe;
        end else begin
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_age_q[n] != AGE_SAT)
                    slot_age_q[n] = slot_age_q[n] + 16'd1;
                online_bits[n] = (slot_age_q[n] < timeout_limit);
            end
        end
        active = enable_bits & ~bypass_bits;
        status.weather_safe = force_safe | ((active & ~(online_bits & safe_bits)) == '0);
        status.online_mask  = online_bits;
        status.safe_mask    = safe_bits;
        return status;
    endfunction

    function automatic void add_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_directed_row row;
        row = '{default: '0};
        row.is_reg_write = 1'b1;
        row.reg_idx      = idx;
        row.reg_data     = data;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cmd(logic func, logic [SLOT_IN_W-1:0] slot, logic rsafe,
                                    bit typed, logic ws, logic [MASK_W-1:0] online,
                                    logic [MASK_W-1:0] safe_m);
        t_directed_row row;
        row = '{default: '0};
        row.cmd    = '{func: func, slot: slot, report_safe: rsafe};
        row.typed  = typed;
        row.status = '{weather_safe: ws, online_mask: online, safe_mask: safe_m};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic log_mismatch(string what, t_interlock_status want,
                                t_interlock_status got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $write("%0t %s: expected safe=%0b online=%02h safe_mask=%02h",
                   $realtime, what, want.weather_safe, want.online_mask, want.safe_mask);
            $display(", got safe=%0b online=%02h safe_mask=%02h",
                     got.weather_safe, got.online_mask, got.safe_mask);
        end
    endtask

    // Hold start until the transaction is taken, then log its expected verdict.
    task automatic send_cmd(t_interlock_cmd cmd, int gap, bit typed,
                            t_interlock_status typed_status);
        t_interlock_status status;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= cmd.func;
        i_sensor_slot <= cmd.slot;
        i_report_safe <= cmd.report_safe;
        do @(posedge i_clk); while (busy);
        status = advance_interlock(cmd);
        verdict_q.insert(verdict_q.size(), typed ? typed_status : status);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ENABLE_MASK:   enable_bits   = data[MASK_W-1:0];
            CFG_BYPASS_MASK:   bypass_bits   = data[MASK_W-1:0];
            CFG_GLOBAL_BYPASS: force_safe    = data[0];
            CFG_TIMEOUT_TICKS: timeout_limit = data[TIMEOUT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_interlock_status got;
        t_interlock_status want;
        got = '{weather_safe: o_weather_safe, online_mask: o_online_mask,
                safe_mask: o_safe_mask};
        if (i_rst_n && o_strobe) begin
            if (verdict_q.size() == 0) begin
                log_mismatch("verdict with no transaction pending", '0, got);
            end else begin
                want = verdict_q.pop_front();
                if (got.weather_safe !== want.weather_safe ||
                    got.online_mask !== want.online_mask ||
                    got.safe_mask !== want.safe_mask)
                    log_mismatch("verdict mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_sensor_heartbeat_safety_interlock_unit: done, errors");
            $finish;
        end
    end

    initial begin
        t_interlock_cmd        cmd;
        t_directed_row         row;
        logic [CFG_DATA_W-1:0] value;
        bit                    quiet;
        int                    roll;

        enable_bits   = '0;
        bypass_bits   = '0;
        force_safe    = 1'b0;
        timeout_limit = TIMEOUT_RESET;
        online_bits   = '0;
        safe_bits     = '0;
        foreach (slot_age_q[n])
            slot_age_q[n] = '0;

        // Never-reported slots come online on the first tick but stay unsafe
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b1, 8'hFF, 8'h00);
        add_cmd(FUNC_REPORT, 3'd0, 1'b1, 1, 1'b1, 8'hFF, 8'h01);
        add_cmd(FUNC_REPORT, 3'd7, 1'b1, 1, 1'b1, 8'hFF, 8'h81);
        add_reg_write(CFG_ENABLE_MASK, 16'h00FF);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b0, 8'hFF, 8'h81);
        add_reg_write(CFG_TIMEOUT_TICKS, 16'd1);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b0, 8'h00, 8'h81);
        add_cmd(FUNC_REPORT, 3'd3, 1'b0, 1, 1'b0, 8'h08, 8'h81);
        // Only slot 3 stays active
        add_reg_write(CFG_BYPASS_MASK, 16'h00F7);
        add_cmd(FUNC_REPORT, 3'd3, 1'b1, 1, 1'b1, 8'h08, 8'h89);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b0, 8'h00, 8'h89);
        add_reg_write(CFG_GLOBAL_BYPASS, 16'd1);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b1, 8'h00, 8'h89);
        add_reg_write(CFG_GLOBAL_BYPASS, 16'd0);
        add_reg_write(CFG_TIMEOUT_TICKS, 16'd0);
        add_reg_write(CFG_BYPASS_MASK, 16'h0000);
        add_reg_write(CFG_ENABLE_MASK, 16'h0000);
        // Zero timeout drops every slot offline on the first tick
        add_cmd(FUNC_REPORT, 3'd5, 1'b1, 1, 1'b1, 8'h20, 8'hA9);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b1, 8'h00, 8'hA9);
        add_reg_write(CFG_TIMEOUT_TICKS, 16'hFFFF);
        add_reg_write(CFG_ENABLE_MASK, 16'h0020);
        add_cmd(FUNC_REPORT, 3'd5, 1'b1, 1, 1'b1, 8'h20, 8'hA9);
        add_cmd(FUNC_TICK,   3'd0, 1'b0, 1, 1'b1, 8'hFF, 8'hA9);
        // Slot and verdict fields are don't-care on a tick
        add_cmd(FUNC_TICK,   3'd7, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        add_cmd(FUNC_REPORT, 3'd5, 1'b0, 1, 1'b0, 8'hFF, 8'h89);
        add_reg_write(CFG_BYPASS_MASK, 16'hFF20);
        add_cmd(FUNC_REPORT, 3'd6, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        add_cmd(FUNC_REPORT, 3'd2, 1'b0, 0, 1'b0, 8'h00, 8'h00);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.is_reg_write) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_cmd(row.cmd, pick_gap(1'b0), row.typed, row.status);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            quiet = ($urandom_range(0, 3) == 0);

            if (phase == 0)
                value = 16'h00FF;
            else if (phase == 1)
                value = 16'h0000;
            else if ($urandom_range(0, 3) == 0)
                value = 16'($urandom());
            else
                value = {8'h00, 8'($urandom())};
            write_reg(CFG_ENABLE_MASK, value);

            if (phase == 2)
                value = 16'h00FF;
            else if ($urandom_range(0, 2) == 0)
                value = 16'($urandom());
            else
                value = '0;
            write_reg(CFG_BYPASS_MASK, value);

            value = (16'($urandom()) & 16'hFFFE) |
                    16'((phase == 3) || ($urandom_range(0, 7) == 0));
            write_reg(CFG_GLOBAL_BYPASS, value);

            roll = $urandom_range(0, 9);
            if (phase == 4)
                value = 16'd0;
            else if (phase == 5)
                value = 16'hFFFF;
            else if (phase == 6)
                value = 16'd1;
            else if (roll < 7)
                value = 16'($urandom_range(1, 12));
            else if (roll < 9)
                value = 16'($urandom_range(13, 200));
            else
                value = 16'($urandom());
            write_reg(CFG_TIMEOUT_TICKS, value);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Let the pipeline drain completely now and then
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
                cmd.func        = ($urandom_range(0, 9) < 3) ? FUNC_TICK : FUNC_REPORT;
                cmd.slot        = SLOT_IN_W'($urandom());
                cmd.report_safe = ($urandom_range(0, 99) < 85);
                send_cmd(cmd, pick_gap(quiet), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("tb_sensor_heartbeat_safety_interlock_unit: done, clean");
        else
            $display("tb_sensor_heartbeat_safety_interlock_unit: done, errors");
        $finish;
    end

endmodule
